### hw/rtl/rhc_pkg.sv
package rhc_pkg;

   // Pixel component and product widths.
   localparam int PIX_W  = 8;
   localparam int PROD_W = 2 * PIX_W;

   // Pipeline layout: two stages of setup, one stage per quotient bit,
   // then the output register in the top level.
   localparam int DIV_FIRST   = 2;
   localparam int DIV_STEPS   = PIX_W;
   localparam int DIV_POS_W   = $clog2(DIV_STEPS);
   localparam int PIPE_DEPTH  = DIV_FIRST + DIV_STEPS;
   localparam int STAGE_COUNT = PIPE_DEPTH + 1;

   // First stage of the delay line that aligns the shorter HSV to RGB path.
   localparam int HSV_DELAY_FIRST = 4;

   localparam int HUE_SECTOR   = 43;
   localparam int REGION_COUNT = 6;

   typedef logic [PIX_W-1:0] pix_type;

   localparam pix_type FULL_SCALE     = 8'd255;
   localparam pix_type HUE_SECTOR_PIX = 8'd43;
   localparam pix_type REM_SCALE      = 8'd6;
   localparam pix_type BASE_RED       = 8'd0;
   localparam pix_type BASE_GREEN     = 8'd85;
   localparam pix_type BASE_BLUE      = 8'd171;

   localparam logic DIR_HSV_TO_RGB = 1'b0;
   localparam logic DIR_RGB_TO_HSV = 1'b1;

   typedef struct packed {
      pix_type first;
      pix_type second;
      pix_type third;
   } pixel_type;

   typedef enum logic [2:0] {
      REGION_0 = 3'd0,
      REGION_1 = 3'd1,
      REGION_2 = 3'd2,
      REGION_3 = 3'd3,
      REGION_4 = 3'd4,
      REGION_5 = 3'd5
   } region_type;

   typedef enum logic [1:0] {
      SRC_RED   = 2'd0,
      SRC_GREEN = 2'd1,
      SRC_BLUE  = 2'd2
   } src_type;

   // Partial state of a restoring divider.
   typedef struct packed {
      logic [PROD_W-1:0] rem;
      pix_type           quo;
      pix_type           dsr;
   } div_type;

   // Values that ride along the divider stages of the RGB to HSV path.
   typedef struct packed {
      pix_type val;
      src_type src;
      logic    neg;
      logic    grey;
   } hsv_side_type;

   // One restoring step: resolves quotient bit bit_pos.
   function automatic div_type div_step(div_type cur, logic [DIV_POS_W-1:0] bit_pos);
      logic [PROD_W-1:0] shifted;
      div_type           nxt;
      shifted = {{(PROD_W-PIX_W){1'b0}}, cur.dsr} << bit_pos;
      nxt     = cur;
      if (cur.rem >= shifted) begin
         nxt.rem          = cur.rem - shifted;
         nxt.quo[bit_pos] = 1'b1;
      end
      return nxt;
   endfunction

endpackage

### hw/rtl/rhc_req_if.sv
interface rhc_req_if;
   import rhc_pkg::*;

   logic    valid;
   logic    ready;
   pix_type in_first;
   pix_type in_second;
   pix_type in_third;

   modport source (output valid, output in_first, output in_second, output in_third,
                   input ready);
   modport sink (input valid, input in_first, input in_second, input in_third,
                 output ready);
endinterface

### hw/rtl/rhc_rsp_if.sv
interface rhc_rsp_if;
   import rhc_pkg::*;

   logic    valid;
   logic    ready;
   pix_type out_first;
   pix_type out_second;
   pix_type out_third;

   modport source (output valid, output out_first, output out_second, output out_third,
                   input ready);
   modport sink (input valid, input out_first, input out_second, input out_third,
                 output ready);
endinterface

### hw/rtl/rgb_hsv_color_convert_unit.sv
// Pixel color converter between 8-bit HSV and 8-bit RGB.
// Pixels arrive as transactions on req_bus and leave as transactions on rsp_bus,
// both valid/ready channels; a transaction moves when valid and ready are high at
// a rising clock edge. Each request transaction yields exactly one response,
// in order.
// csr_wr_en/csr_wr_data write the direction bit: 0 converts HSV to RGB, 1 converts
// RGB to HSV. Change it only while no transaction is in flight.
// Throughput is one transaction per clock while the receiver keeps up. Every stage
// is registered and the two divides of the RGB to HSV path resolve one quotient
// bit per stage, so their eight steps set the depth of the pipeline.
// Each stage holds its item until the next stage has room. When the receiver
// stalls, the response stays on rsp_bus unchanged and requests keep entering
// until every stage is full; then req_bus.ready drops.
// Reset (synchronous, active high) empties the pipeline and sets the
// direction to HSV to RGB.
module rgb_hsv_color_convert_unit (
   input logic       clock,
   input logic       reset,
   rhc_req_if.sink   req_bus,
   rhc_rsp_if.source rsp_bus,
   input logic       csr_wr_en,
   input logic       csr_wr_data
);
   import rhc_pkg::*;

   // Direction register.
   logic dir_cfg_ff;

   // Per-stage occupancy, the direction each item was accepted under, and the
   // per-stage advance strobes.
   logic [STAGE_COUNT-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0]  dir_ff;
   logic [STAGE_COUNT-1:0] stage_adv;

   pixel_type req_pix;
   pixel_type hsv_pix;
   pixel_type rgb_pix;
   pixel_type out_ff;
   logic      out_dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_cfg_ff <= DIR_HSV_TO_RGB;
      end else if (csr_wr_en) begin
         dir_cfg_ff <= csr_wr_data;
      end
   end

   // A stage may load when it is empty or when its item moves on in the same
   // cycle. Bubbles are squeezed out, so requests are still taken while the
   // output register waits on the receiver.
   always_comb begin
      stage_adv[STAGE_COUNT-1] = !valid_ff[STAGE_COUNT-1] || rsp_bus.ready;
      for (int k = STAGE_COUNT - 2; k >= 0; k--) begin
         stage_adv[k] = !valid_ff[k] || stage_adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_adv[0]) begin
            valid_ff[0] <= req_bus.valid;
         end
         for (int k = 1; k < STAGE_COUNT; k++) begin
            if (stage_adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv[0]) begin
         dir_ff[0] <= dir_cfg_ff;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         if (stage_adv[k]) begin
            dir_ff[k] <= dir_ff[k-1];
         end
      end
   end

   assign req_bus.ready = stage_adv[0];
   assign req_pix = '{first: req_bus.in_first, second: req_bus.in_second,
                      third: req_bus.in_third};

   // Both datapaths see every pixel; the direction picks one at the output.
   rhc_hsv2rgb u_hsv2rgb (
      .clock    (clock),
      .stage_en (stage_adv[PIPE_DEPTH-1:0]),
      .pix_in   (req_pix),
      .pix_out  (hsv_pix)
   );

   rhc_rgb2hsv u_rgb2hsv (
      .clock    (clock),
      .stage_en (stage_adv[PIPE_DEPTH-1:0]),
      .pix_in   (req_pix),
      .pix_out  (rgb_pix)
   );

   // Output register: the response stage.
   always_ff @(posedge clock) begin
      if (stage_adv[STAGE_COUNT-1]) begin
         out_ff     <= (dir_ff[PIPE_DEPTH-1] == DIR_RGB_TO_HSV) ? rgb_pix : hsv_pix;
         out_dir_ff <= dir_ff[PIPE_DEPTH-1];
      end
   end

   assign rsp_bus.valid      = valid_ff[STAGE_COUNT-1];
   assign rsp_bus.out_first  = out_ff.first;
   assign rsp_bus.out_second = out_ff.second;
   assign rsp_bus.out_third  = out_ff.third;

`ifndef ASSERT_OFF
   // An empty first stage must always be able to take a request.
   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> req_bus.ready)
      else $error("request refused with first stage empty");

   // An accepted request occupies the first stage on the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> valid_ff[0])
      else $error("accepted request lost at pipeline entry");

   // RGB to HSV: a black pixel has zero hue and saturation.
   a_black_hsv: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && out_dir_ff == DIR_RGB_TO_HSV && rsp_bus.out_third == '0)
      |-> (rsp_bus.out_first == '0 && rsp_bus.out_second == '0))
      else $error("black pixel gave nonzero hue or saturation");

   // RGB to HSV: zero saturation forces zero hue.
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && out_dir_ff == DIR_RGB_TO_HSV && rsp_bus.out_second == '0)
      |-> (rsp_bus.out_first == '0))
      else $error("grey pixel gave nonzero hue");
`endif

endmodule

### hw/rtl/rhc_hsv2rgb.sv
module rhc_hsv2rgb (
   input  logic                           clock,
   input  logic [rhc_pkg::PIPE_DEPTH-1:0] stage_en,
   input  rhc_pkg::pixel_type             pix_in,
   output rhc_pkg::pixel_type             pix_out
);
   import rhc_pkg::*;

   // Stage 0: hue region and scaled remainder.
   region_type s0_region_in, s0_region_ff;
   pix_type    s0_rem_in, s0_rem_ff;
   pix_type    s0_sat_ff, s0_val_ff;
   logic       s0_grey_ff;
   pix_type    sector_base;

   // Stage 1: first products, kept as their upper bytes.
   pix_type    s1_p_in, s1_p_ff;
   pix_type    s1_sr_in, s1_sr_ff;
   pix_type    s1_st_in, s1_st_ff;
   logic [PROD_W-1:0] prod_p, prod_sr, prod_st;
   pix_type    s1_val_ff;
   region_type s1_region_ff;
   logic       s1_grey_ff;

   // Stage 2: q and t.
   logic [PROD_W-1:0] prod_q, prod_t;
   pix_type    s2_p_ff, s2_q_ff, s2_t_ff, s2_val_ff;
   region_type s2_region_ff;
   logic       s2_grey_ff;

   // Stage 3 onward: finished pixel and its alignment delay.
   pixel_type  s3_pix_in;
   pixel_type  dly_ff [HSV_DELAY_FIRST-1:PIPE_DEPTH-1];

   always_comb begin
      s0_region_in = REGION_0;
      sector_base  = '0;
      for (int k = 1; k < REGION_COUNT; k++) begin
         if (pix_in.first >= PIX_W'(k * HUE_SECTOR)) begin
            s0_region_in = region_type'(3'(k));
            sector_base  = PIX_W'(k * HUE_SECTOR);
         end
      end
      s0_rem_in = PIX_W'((pix_in.first - sector_base) * REM_SCALE);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_region_ff <= s0_region_in;
         s0_rem_ff    <= s0_rem_in;
         s0_sat_ff    <= pix_in.second;
         s0_val_ff    <= pix_in.third;
         s0_grey_ff   <= (pix_in.second == '0);
      end
   end

   assign prod_p  = PROD_W'(s0_val_ff) * PROD_W'(FULL_SCALE - s0_sat_ff);
   assign prod_sr = PROD_W'(s0_sat_ff) * PROD_W'(s0_rem_ff);
   assign prod_st = PROD_W'(s0_sat_ff) * PROD_W'(FULL_SCALE - s0_rem_ff);
   assign s1_p_in  = prod_p[PROD_W-1:PIX_W];
   assign s1_sr_in = prod_sr[PROD_W-1:PIX_W];
   assign s1_st_in = prod_st[PROD_W-1:PIX_W];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_p_ff      <= s1_p_in;
         s1_sr_ff     <= s1_sr_in;
         s1_st_ff     <= s1_st_in;
         s1_val_ff    <= s0_val_ff;
         s1_region_ff <= s0_region_ff;
         s1_grey_ff   <= s0_grey_ff;
      end
   end

   assign prod_q = PROD_W'(s1_val_ff) * PROD_W'(FULL_SCALE - s1_sr_ff);
   assign prod_t = PROD_W'(s1_val_ff) * PROD_W'(FULL_SCALE - s1_st_ff);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s2_p_ff      <= s1_p_ff;
         s2_q_ff      <= prod_q[PROD_W-1:PIX_W];
         s2_t_ff      <= prod_t[PROD_W-1:PIX_W];
         s2_val_ff    <= s1_val_ff;
         s2_region_ff <= s1_region_ff;
         s2_grey_ff   <= s1_grey_ff;
      end
   end

   always_comb begin
      case (s2_region_ff)
         REGION_0: s3_pix_in = '{first: s2_val_ff, second: s2_t_ff, third: s2_p_ff};
         REGION_1: s3_pix_in = '{first: s2_q_ff, second: s2_val_ff, third: s2_p_ff};
         REGION_2: s3_pix_in = '{first: s2_p_ff, second: s2_val_ff, third: s2_t_ff};
         REGION_3: s3_pix_in = '{first: s2_p_ff, second: s2_q_ff, third: s2_val_ff};
         REGION_4: s3_pix_in = '{first: s2_t_ff, second: s2_p_ff, third: s2_val_ff};
         default:  s3_pix_in = '{first: s2_val_ff, second: s2_p_ff, third: s2_q_ff};
      endcase
      // Zero saturation is a grey pixel at the input value.
      if (s2_grey_ff) begin
         s3_pix_in = '{first: s2_val_ff, second: s2_val_ff, third: s2_val_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[HSV_DELAY_FIRST-1]) begin
         dly_ff[HSV_DELAY_FIRST-1] <= s3_pix_in;
      end
      for (int k = HSV_DELAY_FIRST; k < PIPE_DEPTH; k++) begin
         if (stage_en[k]) begin
            dly_ff[k] <= dly_ff[k-1];
         end
      end
   end

   assign pix_out = dly_ff[PIPE_DEPTH-1];

endmodule

### hw/rtl/rhc_rgb2hsv.sv
module rhc_rgb2hsv (
   input  logic                           clock,
   input  logic [rhc_pkg::PIPE_DEPTH-1:0] stage_en,
   input  rhc_pkg::pixel_type             pix_in,
   output rhc_pkg::pixel_type             pix_out
);
   import rhc_pkg::*;

   // Stage 0: extremes, winning component and signed difference.
   pix_type      s0_max_in, s0_max_ff;
   pix_type      s0_min_in;
   src_type      s0_src_in, s0_src_ff;
   logic [PIX_W:0] diff_in;
   pix_type      s0_mag_in, s0_mag_ff;
   pix_type      s0_span_ff;
   logic         s0_neg_ff;

   // Stage 1 onward: the two dividers and the values that ride with them.
   div_type      sat_div_in, hue_div_in;
   div_type      sat_div_ff [DIV_FIRST-1:PIPE_DEPTH-1];
   div_type      hue_div_ff [DIV_FIRST-1:PIPE_DEPTH-1];
   hsv_side_type side_ff    [DIV_FIRST-1:PIPE_DEPTH-1];

   hsv_side_type last_side;
   pix_type      hue_base;
   pix_type      hue_ofs;

   always_comb begin
      if (pix_in.first >= pix_in.second && pix_in.first >= pix_in.third) begin
         s0_src_in = SRC_RED;
         s0_max_in = pix_in.first;
      end else if (pix_in.second >= pix_in.third) begin
         s0_src_in = SRC_GREEN;
         s0_max_in = pix_in.second;
      end else begin
         s0_src_in = SRC_BLUE;
         s0_max_in = pix_in.third;
      end

      s0_min_in = pix_in.first;
      if (pix_in.second < s0_min_in) begin
         s0_min_in = pix_in.second;
      end
      if (pix_in.third < s0_min_in) begin
         s0_min_in = pix_in.third;
      end

      case (s0_src_in)
         SRC_RED:   diff_in = {1'b0, pix_in.second} - {1'b0, pix_in.third};
         SRC_GREEN: diff_in = {1'b0, pix_in.third} - {1'b0, pix_in.first};
         default:   diff_in = {1'b0, pix_in.first} - {1'b0, pix_in.second};
      endcase

      // The hue divide works on the magnitude so that it truncates toward zero.
      s0_mag_in = diff_in[PIX_W] ? PIX_W'(-diff_in) : diff_in[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_max_ff  <= s0_max_in;
         s0_span_ff <= s0_max_in - s0_min_in;
         s0_src_ff  <= s0_src_in;
         s0_neg_ff  <= diff_in[PIX_W];
         s0_mag_ff  <= s0_mag_in;
      end
   end

   always_comb begin
      sat_div_in.rem = PROD_W'(s0_span_ff) * PROD_W'(FULL_SCALE);
      sat_div_in.quo = '0;
      sat_div_in.dsr = s0_max_ff;
      hue_div_in.rem = PROD_W'(s0_mag_ff) * PROD_W'(HUE_SECTOR_PIX);
      hue_div_in.quo = '0;
      hue_div_in.dsr = s0_span_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[DIV_FIRST-1]) begin
         sat_div_ff[DIV_FIRST-1] <= sat_div_in;
         hue_div_ff[DIV_FIRST-1] <= hue_div_in;
         // A zero span covers black as well: both give hue and saturation zero.
         side_ff[DIV_FIRST-1]    <= '{val: s0_max_ff, src: s0_src_ff, neg: s0_neg_ff,
                                      grey: (s0_span_ff == '0)};
      end
      for (int k = DIV_FIRST; k < PIPE_DEPTH; k++) begin
         if (stage_en[k]) begin
            sat_div_ff[k] <= div_step(sat_div_ff[k-1], DIV_POS_W'(DIV_STEPS - 1 - (k - DIV_FIRST)));
            hue_div_ff[k] <= div_step(hue_div_ff[k-1], DIV_POS_W'(DIV_STEPS - 1 - (k - DIV_FIRST)));
            side_ff[k]    <= side_ff[k-1];
         end
      end
   end

   assign last_side = side_ff[PIPE_DEPTH-1];

   always_comb begin
      case (last_side.src)
         SRC_RED:   hue_base = BASE_RED;
         SRC_GREEN: hue_base = BASE_GREEN;
         default:   hue_base = BASE_BLUE;
      endcase
      hue_ofs = last_side.neg ? PIX_W'(-hue_div_ff[PIPE_DEPTH-1].quo)
                              : hue_div_ff[PIPE_DEPTH-1].quo;

      pix_out.third = last_side.val;
      if (last_side.grey) begin
         pix_out.first  = '0;
         pix_out.second = '0;
      end else begin
         pix_out.first  = hue_base + hue_ofs;
         pix_out.second = sat_div_ff[PIPE_DEPTH-1].quo;
      end
   end

endmodule

### tb/rhc_convert_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps the expected pixels in order and compares every
// response transaction against the oldest one waiting.
module rhc_convert_checker (
   input  logic clock,
   input  logic reset,
   rhc_req_if   req_mon,
   rhc_rsp_if   rsp_mon,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   output int   mismatch_count,
   output int   outstanding
);
   import rhc_pkg::*;

   pixel_type expected_pixels[$];
   logic      direction_q;

   function automatic pixel_type hsv_to_rgb_pixel(pix_type hue, pix_type sat, pix_type val);
      int unsigned h, s, v, region, rem, p, q, t;
      pixel_type   px;
      h = 32'(hue);
      s = 32'(sat);
      v = 32'(val);
      if (s == 0) begin
         px = '{first: val, second: val, third: val};
         return px;
      end
      region = h / HUE_SECTOR;
      rem    = (h - region * HUE_SECTOR) * 32'(REM_SCALE);
      p      = (v * (32'(FULL_SCALE) - s)) >> 8;
      q      = (v * (32'(FULL_SCALE) - ((s * rem) >> 8))) >> 8;
      t      = (v * (32'(FULL_SCALE) - ((s * (32'(FULL_SCALE) - rem)) >> 8))) >> 8;
      case (region_type'(region))
         REGION_0: px = '{first: v[7:0], second: t[7:0], third: p[7:0]};
         REGION_1: px = '{first: q[7:0], second: v[7:0], third: p[7:0]};
         REGION_2: px = '{first: p[7:0], second: v[7:0], third: t[7:0]};
         REGION_3: px = '{first: p[7:0], second: q[7:0], third: v[7:0]};
         REGION_4: px = '{first: t[7:0], second: p[7:0], third: v[7:0]};
         default:  px = '{first: v[7:0], second: p[7:0], third: q[7:0]};
      endcase
      return px;
   endfunction

   function automatic pixel_type rgb_to_hsv_pixel(pix_type red, pix_type green, pix_type blue);
      int        r, g, b, mn, mx, d, base, diff, hue, sat;
      pixel_type px;
      r  = int'(red);
      g  = int'(green);
      b  = int'(blue);
      mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      px = '0;
      px.third = pix_type'(mx);
      if (mx == 0) return px;
      d   = mx - mn;
      sat = (int'(FULL_SCALE) * d) / mx;
      px.second = pix_type'(sat);
      if (sat == 0) return px;
      // Ties on the maximum resolve red first, then green.
      if (mx == r) begin
         base = int'(BASE_RED);
         diff = g - b;
      end else if (mx == g) begin
         base = int'(BASE_GREEN);
         diff = b - r;
      end else begin
         base = int'(BASE_BLUE);
         diff = r - g;
      end
      // Signed division truncates toward zero; the cast wraps a negative hue.
      hue = base + (int'(HUE_SECTOR) * diff) / d;
      px.first = pix_type'(hue);
      return px;
   endfunction

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      direction_q    = DIR_HSV_TO_RGB;
   end

   always @(posedge clock) begin : watch
      pixel_type want;
      if (reset) begin
         direction_q <= DIR_HSV_TO_RGB;
         expected_pixels.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("response transaction with no request waiting");
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_mon.out_first !== want.first) begin
                  $error("out_first: expected %0d, actual %0d", want.first, rsp_mon.out_first);
                  mismatch_count++;
               end
               if (rsp_mon.out_second !== want.second) begin
                  $error("out_second: expected %0d, actual %0d", want.second,
                         rsp_mon.out_second);
                  mismatch_count++;
               end
               if (rsp_mon.out_third !== want.third) begin
                  $error("out_third: expected %0d, actual %0d", want.third, rsp_mon.out_third);
                  mismatch_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (direction_q == DIR_HSV_TO_RGB)
               expected_pixels.push_back(hsv_to_rgb_pixel(req_mon.in_first, req_mon.in_second,
                                                          req_mon.in_third));
            else
               expected_pixels.push_back(rgb_to_hsv_pixel(req_mon.in_first, req_mon.in_second,
                                                          req_mon.in_third));
         end
         if (csr_wr_en) direction_q <= csr_wr_data;
      end
      outstanding <= expected_pixels.size();
   end

endmodule

### tb/tb_rgb_hsv_color_convert_unit.sv
`timescale 1ns / 100ps

// Top of the color converter testbench. It makes the clock and the reset,
// drives pixel transactions into the block and pulls responses out of it.
// All checking lives in the checker instance beside the block; this module
// only produces stimulus and gives the verdict at the end.
module tb_rgb_hsv_color_convert_unit;
   import rhc_pkg::*;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;
   int   mismatch_count;
   int   outstanding;

   // Random idling on both channels is enabled while this is high.
   logic idle_on = 1'b1;
   // Every toggle asks the response side for one long hold-off.
   logic hold_trigger = 1'b0;

   rhc_req_if req_bus ();
   rhc_rsp_if rsp_bus ();

   rgb_hsv_color_convert_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rhc_convert_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs on either handshake. The timeout
   // leaves a wide margin over the slowest legal run.
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Response side. Ready is redrawn on every rising edge. When a hold-off is
   // requested, ready stays low for a long stretch so the pipeline fills up
   // and the block has to drop ready on the request side.
   initial begin : response_sink
      int   hold_left;
      logic hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_trigger) begin
            hold_seen = hold_trigger;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !idle_on || ($urandom_range(99) >= 36);
         end
      end
   end

   // Offers one pixel and returns at the edge where the transaction is taken.
   // Valid stays high on return so back-to-back pixels leave no bubble; it is
   // only lowered by a random gap in front of the next pixel or by a drain.
   task automatic send_pixel(input pix_type a, input pix_type b, input pix_type c);
      while (idle_on && $urandom_range(99) < 36) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.in_first  <= a;
      req_bus.in_second <= b;
      req_bus.in_third  <= c;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Stops offering and waits until every expected response has come back.
   // The checker updates its count after each edge, so the first look waits for
   // the next edge, when the last accepted request is already counted.
   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // The direction may only change while nothing is in flight, so the
   // pipeline is drained before the write.
   task automatic set_direction(input logic dir);
      drain_pipeline();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= dir;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random pixel with a bias toward the corners of each conversion: grey,
   // black, the last hue region and ties on the largest component. Plain
   // uniform draws make up the rest and toggle every input bit.
   task automatic send_random_pixel(input logic dir);
      pix_type     a, b, c;
      int unsigned pick;
      a    = pix_type'($urandom);
      b    = pix_type'($urandom);
      c    = pix_type'($urandom);
      pick = $urandom_range(15);
      if (dir == DIR_HSV_TO_RGB) begin
         if (pick < 2) b = '0;
         else if (pick < 4) a = pix_type'($urandom_range(255, 215));
      end else begin
         if (pick < 2) begin
            b = a;
            c = a;
         end else if (pick == 2) begin
            a = '0;
            b = '0;
            c = '0;
         end else if (pick < 5) begin
            b = a;
         end else if (pick < 7) begin
            c = b;
         end else if (pick == 7) begin
            c = a;
         end
      end
      send_pixel(a, b, c);
   endtask

   initial begin : stimulus
      logic dir;
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= 1'b0;
      req_bus.valid     <= 1'b0;
      req_bus.in_first  <= '0;
      req_bus.in_second <= '0;
      req_bus.in_third  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // HSV to RGB straight out of reset: grey, region edges, the last
      // region and the extremes of every field.
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd0,   8'd200);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd42,  8'd255, 8'd255);
      send_pixel(8'd43,  8'd255, 8'd255);
      send_pixel(8'd86,  8'd200, 8'd180);
      send_pixel(8'd129, 8'd128, 8'd255);
      send_pixel(8'd172, 8'd255, 8'd100);
      send_pixel(8'd214, 8'd255, 8'd255);
      send_pixel(8'd215, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd1,   8'd255);

      // RGB to HSV: black, grey, each primary, every kind of tie on the
      // maximum and a hue that wraps below zero.
      set_direction(DIR_RGB_TO_HSV);
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd77,  8'd77,  8'd77);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd200, 8'd50,  8'd100);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd254, 8'd253);
      send_pixel(8'd10,  8'd200, 8'd90);

      // Random phases alternate the direction. One phase runs without any
      // idling, two phases contain a long response hold-off, and one has the
      // sender pause midway until the pipeline is empty.
      for (int phase = 0; phase < 6; phase++) begin
         dir = (phase % 2 == 0) ? DIR_HSV_TO_RGB : DIR_RGB_TO_HSV;
         set_direction(dir);
         idle_on <= (phase != 2);
         for (int n = 0; n < 100; n++) begin
            if ((phase == 1 && n == 20) || (phase == 3 && n == 40))
               hold_trigger <= ~hold_trigger;
            if (phase == 4 && n == 50) drain_pipeline();
            send_random_pixel(dir);
         end
         drain_pipeline();
         idle_on <= 1'b1;
      end

      // Everything has drained; keep watching the block in case it emits
      // something it should not, then decide.
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
